/* design/tqprs_pkg.sv */
// ----------------------------------------------------------------------------
// tqprs_pkg
// Shared types and constants for the two-queue runway scheduler.
// ----------------------------------------------------------------------------
package tqprs_pkg;

  // Field widths fixed by the transaction format
  localparam int REQ_W  = 4;
  localparam int ID_W   = 32;
  localparam int REF_W  = 5;
  localparam int OCC_W  = 3;
  localparam int KIND_W = 2;
  // Internal occupancy width, wide enough for any supported queue depth
  localparam int CNTX_W = 8;

  // Per-tick request count limit
  localparam int MAX_BURST = 15;

  // Runway outcome codes
  typedef enum logic [KIND_W-1:0] {
    KIND_IDLE = 2'd0,
    KIND_LAND = 2'd1,
    KIND_TAKE = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAND,
    ST_TAKE,
    ST_READ,
    ST_RESP
  } state_t;

  // One queue entry: plane id and enqueue tick
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] tick;
  } entry_t;

  // Service result from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   wait_val;
    logic [REF_W-1:0]  refused;
    logic [CNTX_W-1:0] land_cnt;
    logic [CNTX_W-1:0] take_cnt;
  } svc_t;

  // Saturating 32-bit add
  function automatic logic [ID_W-1:0] sat_add(input logic [ID_W-1:0] a,
                                              input logic [ID_W-1:0] b);
    logic [ID_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ID_W] ? {ID_W{1'b1}} : s[ID_W-1:0];
  endfunction

  // Occupancy clipped to the 3-bit result field
  function automatic logic [OCC_W-1:0] occ_sat(input logic [CNTX_W-1:0] c);
    return (c > CNTX_W'(7)) ? OCC_W'(7) : c[OCC_W-1:0];
  endfunction

endpackage

/* design/tqprs_in_if.sv */
// ----------------------------------------------------------------------------
// tqprs_in_if
// Tick request channel: landing and takeoff request counts.
// ----------------------------------------------------------------------------
interface tqprs_in_if;
  logic                      valid;
  logic                      ready;
  logic [tqprs_pkg::REQ_W-1:0] arrivals;
  logic [tqprs_pkg::REQ_W-1:0] departures;

  modport source (output valid, output arrivals, output departures, input ready);
  modport sink   (input valid, input arrivals, input departures, output ready);
endinterface

/* design/tqprs_out_if.sv */
// ----------------------------------------------------------------------------
// tqprs_out_if
// Per-tick result channel: served plane, occupancies and running totals.
// ----------------------------------------------------------------------------
interface tqprs_out_if;
  logic                         valid;
  logic                         ready;
  logic [tqprs_pkg::KIND_W-1:0] served_kind;
  logic [tqprs_pkg::ID_W-1:0]   plane_id;
  logic [tqprs_pkg::ID_W-1:0]   wait_res;
  logic [tqprs_pkg::REF_W-1:0]  refused_now;
  logic [tqprs_pkg::OCC_W-1:0]  land_waiting;
  logic [tqprs_pkg::OCC_W-1:0]  takeoff_waiting;
  logic [tqprs_pkg::ID_W-1:0]   total_landed;
  logic [tqprs_pkg::ID_W-1:0]   total_taken_off;
  logic [tqprs_pkg::ID_W-1:0]   total_refused;
  logic [tqprs_pkg::ID_W-1:0]   total_idle;
  logic [tqprs_pkg::ID_W-1:0]   total_land_wait;
  logic [tqprs_pkg::ID_W-1:0]   total_takeoff_wait;

  modport source (output valid, output served_kind, output plane_id, output wait_res,
                  output refused_now, output land_waiting, output takeoff_waiting,
                  output total_landed, output total_taken_off, output total_refused,
                  output total_idle, output total_land_wait, output total_takeoff_wait,
                  input ready);
  modport sink   (input valid, input served_kind, input plane_id, input wait_res,
                  input refused_now, input land_waiting, input takeoff_waiting,
                  input total_landed, input total_taken_off, input total_refused,
                  input total_idle, input total_land_wait, input total_takeoff_wait,
                  output ready);
endinterface

/* design/tqprs_ram.sv */
// ----------------------------------------------------------------------------
// tqprs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tqprs_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/tqprs_ctl.sv */
// ----------------------------------------------------------------------------
// tqprs_ctl
// Tick sequencer: admits requests one per cycle into the queue RAM, then
// reads the head of the chosen queue and presents the served plane.
// ----------------------------------------------------------------------------
module tqprs_ctl #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [tqprs_pkg::REQ_W-1:0] in_arrivals,
  input  logic [tqprs_pkg::REQ_W-1:0] in_departures,
  output logic                        in_ready,
  output tqprs_pkg::svc_t             svc_o,
  input  logic                        svc_ready_i
);

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = SLOT_W + 1;
  localparam int REQ_W  = tqprs_pkg::REQ_W;
  localparam int ID_W   = tqprs_pkg::ID_W;
  localparam int REF_W  = tqprs_pkg::REF_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic              Q_LAND    = 1'b0;
  localparam logic              Q_TAKE    = 1'b1;

  tqprs_pkg::state_t state_r, state_nxt;
  tqprs_pkg::kind_t  kind_r, kind_nxt;

  logic [SLOT_W-1:0] lhead_r, lhead_nxt, ltail_r, ltail_nxt;
  logic [SLOT_W-1:0] thead_r, thead_nxt, ttail_r, ttail_nxt;
  logic [CNT_W-1:0]  lcnt_r, lcnt_nxt, tcnt_r, tcnt_nxt;
  logic [ID_W-1:0]   tick_r, tick_nxt, plane_r, plane_nxt;
  logic [REQ_W-1:0]  left_r, left_nxt, dep_r, dep_nxt;
  logic [REF_W-1:0]  refused_r, refused_nxt;

  logic                    wr_en, rd_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  tqprs_pkg::entry_t       wr_entry, rd_entry;
  logic [$bits(tqprs_pkg::entry_t)-1:0] rd_raw;

  logic [CNT_W-1:0] lcnt_after, tcnt_after;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [REQ_W-1:0] clamp(input logic [REQ_W-1:0] n);
    return ({4'b0, n} > 8'(tqprs_pkg::MAX_BURST)) ? REQ_W'(tqprs_pkg::MAX_BURST) : n;
  endfunction

  // Queue storage: landing entries in the lower half, takeoff in the upper
  tqprs_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W ($bits(tqprs_pkg::entry_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = tqprs_pkg::entry_t'(rd_raw);

  // State and queue bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tqprs_pkg::ST_IDLE;
      kind_r    <= tqprs_pkg::KIND_IDLE;
      lhead_r   <= '0;
      ltail_r   <= LAST_SLOT;
      lcnt_r    <= '0;
      thead_r   <= '0;
      ttail_r   <= LAST_SLOT;
      tcnt_r    <= '0;
      tick_r    <= ID_W'(1);
      plane_r   <= '0;
      left_r    <= '0;
      dep_r     <= '0;
      refused_r <= '0;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      lhead_r   <= lhead_nxt;
      ltail_r   <= ltail_nxt;
      lcnt_r    <= lcnt_nxt;
      thead_r   <= thead_nxt;
      ttail_r   <= ttail_nxt;
      tcnt_r    <= tcnt_nxt;
      tick_r    <= tick_nxt;
      plane_r   <= plane_nxt;
      left_r    <= left_nxt;
      dep_r     <= dep_nxt;
      refused_r <= refused_nxt;
    end
  end

  // Occupancies once the served plane leaves
  assign lcnt_after = (kind_r == tqprs_pkg::KIND_LAND) ? lcnt_r - CNT_W'(1) : lcnt_r;
  assign tcnt_after = (kind_r == tqprs_pkg::KIND_TAKE) ? tcnt_r - CNT_W'(1) : tcnt_r;

  // Next state, RAM accesses and result
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    lhead_nxt   = lhead_r;
    ltail_nxt   = ltail_r;
    lcnt_nxt    = lcnt_r;
    thead_nxt   = thead_r;
    ttail_nxt   = ttail_r;
    tcnt_nxt    = tcnt_r;
    tick_nxt    = tick_r;
    plane_nxt   = plane_r;
    left_nxt    = left_r;
    dep_nxt     = dep_r;
    refused_nxt = refused_r;
    in_ready    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = {Q_LAND, ltail_r};
    wr_entry    = '{id: plane_r + ID_W'(1), tick: tick_r};
    rd_en       = 1'b0;
    rd_addr     = {Q_LAND, lhead_r};

    svc_o          = '0;
    svc_o.kind     = kind_r;
    svc_o.refused  = refused_r;
    svc_o.land_cnt = tqprs_pkg::CNTX_W'(lcnt_after);
    svc_o.take_cnt = tqprs_pkg::CNTX_W'(tcnt_after);

    case (state_r)
      tqprs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          left_nxt    = clamp(in_arrivals);
          dep_nxt     = clamp(in_departures);
          refused_nxt = '0;
          state_nxt   = tqprs_pkg::ST_LAND;
        end
      end
      // One landing request per cycle
      tqprs_pkg::ST_LAND: begin
        if (left_r == '0) begin
          left_nxt  = dep_r;
          state_nxt = tqprs_pkg::ST_TAKE;
        end else begin
          left_nxt  = left_r - REQ_W'(1);
          plane_nxt = plane_r + ID_W'(1);
          if (lcnt_r == FULL_CNT) begin
            refused_nxt = refused_r + REF_W'(1);
          end else begin
            wr_en     = 1'b1;
            wr_addr   = {Q_LAND, next_slot(ltail_r)};
            ltail_nxt = next_slot(ltail_r);
            lcnt_nxt  = lcnt_r + CNT_W'(1);
          end
        end
      end
      // One takeoff request per cycle
      tqprs_pkg::ST_TAKE: begin
        if (left_r == '0) begin
          state_nxt = tqprs_pkg::ST_READ;
        end else begin
          left_nxt  = left_r - REQ_W'(1);
          plane_nxt = plane_r + ID_W'(1);
          if (tcnt_r == FULL_CNT) begin
            refused_nxt = refused_r + REF_W'(1);
          end else begin
            wr_en     = 1'b1;
            wr_addr   = {Q_TAKE, next_slot(ttail_r)};
            ttail_nxt = next_slot(ttail_r);
            tcnt_nxt  = tcnt_r + CNT_W'(1);
          end
        end
      end
      // Pick a queue and read its head; all writes for this tick are done
      tqprs_pkg::ST_READ: begin
        state_nxt = tqprs_pkg::ST_RESP;
        if (lcnt_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = {Q_LAND, lhead_r};
          kind_nxt = tqprs_pkg::KIND_LAND;
        end else if (tcnt_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = {Q_TAKE, thead_r};
          kind_nxt = tqprs_pkg::KIND_TAKE;
        end else begin
          kind_nxt = tqprs_pkg::KIND_IDLE;
        end
      end
      // Present the served plane; retire the tick once the output takes it
      tqprs_pkg::ST_RESP: begin
        svc_o.valid = 1'b1;
        if (kind_r != tqprs_pkg::KIND_IDLE) begin
          svc_o.id       = rd_entry.id;
          svc_o.wait_val = tick_r - rd_entry.tick;
        end
        if (svc_ready_i) begin
          lcnt_nxt  = lcnt_after;
          tcnt_nxt  = tcnt_after;
          tick_nxt  = tick_r + ID_W'(1);
          state_nxt = tqprs_pkg::ST_IDLE;
          if (kind_r == tqprs_pkg::KIND_LAND) begin
            lhead_nxt = next_slot(lhead_r);
          end
          if (kind_r == tqprs_pkg::KIND_TAKE) begin
            thead_nxt = next_slot(thead_r);
          end
        end
      end
      default: begin
        state_nxt = tqprs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/two_queue_priority_runway_scheduler.sv */
// ----------------------------------------------------------------------------
// two_queue_priority_runway_scheduler
// Strict-priority runway scheduler: landing and takeoff FIFOs held in one
// RAM, at most one plane served per tick, with saturating running totals.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Handshake     | Payload
//   --------+-----+---------------+----------------------------------------
//   in_ch   | in  | valid/ready   | arrivals, departures (one tick)
//   out_ch  | out | valid/ready   | served plane, wait, refusals, totals
//
// For each tick the sequencer accepts the counts, admits each request (A
// and D after clamping) in its own turn on the single RAM write port, passes
// two phase changes, reads the queue head and presents the response.
// Reset is synchronous and clears all control state; no clearing pass.
// A finished result waits in the output register while the next tick is
// accepted and admitted; the sequencer stalls only when it must hand over
// a new result and the output register is still full.
// ----------------------------------------------------------------------------
module two_queue_priority_runway_scheduler #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  tqprs_in_if.sink            in_ch,
  tqprs_out_if.source         out_ch
);

  localparam int ID_W = tqprs_pkg::ID_W;

  tqprs_pkg::svc_t svc;
  logic            svc_ready;
  logic            svc_take;

  logic                        out_valid_r, out_valid_nxt;
  tqprs_pkg::kind_t            kind_r;
  logic [ID_W-1:0]             id_r, wait_r;
  logic [tqprs_pkg::REF_W-1:0] refused_r;
  logic [tqprs_pkg::OCC_W-1:0] lwait_r, twait_r;

  logic [ID_W-1:0] landed_r, landed_nxt, took_r, took_nxt;
  logic [ID_W-1:0] refsum_r, refsum_nxt, idle_r, idle_nxt;
  logic [ID_W-1:0] lwsum_r, lwsum_nxt, twsum_r, twsum_nxt;

  // Sequencer with queue RAM
  tqprs_ctl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_arrivals   (in_ch.arrivals),
    .in_departures (in_ch.departures),
    .in_ready      (in_ch.ready),
    .svc_o         (svc),
    .svc_ready_i   (svc_ready)
  );

  assign svc_ready = !out_valid_r || out_ch.ready;
  assign svc_take  = svc.valid && svc_ready;

  // Running totals
  always_comb begin
    landed_nxt = landed_r;
    took_nxt   = took_r;
    idle_nxt   = idle_r;
    lwsum_nxt  = lwsum_r;
    twsum_nxt  = twsum_r;
    refsum_nxt = tqprs_pkg::sat_add(refsum_r, ID_W'(svc.refused));
    case (svc.kind)
      tqprs_pkg::KIND_LAND: begin
        landed_nxt = tqprs_pkg::sat_add(landed_r, ID_W'(1));
        lwsum_nxt  = tqprs_pkg::sat_add(lwsum_r, svc.wait_val);
      end
      tqprs_pkg::KIND_TAKE: begin
        took_nxt  = tqprs_pkg::sat_add(took_r, ID_W'(1));
        twsum_nxt = tqprs_pkg::sat_add(twsum_r, svc.wait_val);
      end
      default: begin
        idle_nxt = tqprs_pkg::sat_add(idle_r, ID_W'(1));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      landed_r <= '0;
      took_r   <= '0;
      refsum_r <= '0;
      idle_r   <= '0;
      lwsum_r  <= '0;
      twsum_r  <= '0;
    end else if (svc_take) begin
      landed_r <= landed_nxt;
      took_r   <= took_nxt;
      refsum_r <= refsum_nxt;
      idle_r   <= idle_nxt;
      lwsum_r  <= lwsum_nxt;
      twsum_r  <= twsum_nxt;
    end
  end

  // Output register
  assign out_valid_nxt = svc_take ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (svc_take) begin
      kind_r    <= svc.kind;
      id_r      <= svc.id;
      wait_r    <= svc.wait_val;
      refused_r <= svc.refused;
      lwait_r   <= tqprs_pkg::occ_sat(svc.land_cnt);
      twait_r   <= tqprs_pkg::occ_sat(svc.take_cnt);
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.served_kind        = kind_r;
  assign out_ch.plane_id           = id_r;
  assign out_ch.wait_res           = wait_r;
  assign out_ch.refused_now        = refused_r;
  assign out_ch.land_waiting       = lwait_r;
  assign out_ch.takeoff_waiting    = twait_r;
  assign out_ch.total_landed       = landed_r;
  assign out_ch.total_taken_off    = took_r;
  assign out_ch.total_refused      = refsum_r;
  assign out_ch.total_idle         = idle_r;
  assign out_ch.total_land_wait    = lwsum_r;
  assign out_ch.total_takeoff_wait = twsum_r;

  // Assertions
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    svc_take |=> out_valid_r)
    else $error("handed-over result not presented");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (svc.valid && svc.kind == tqprs_pkg::KIND_IDLE) |-> (svc.id == '0 && svc.wait_val == '0))
    else $error("idle tick carries a plane id or wait");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (svc_take && svc.kind != tqprs_pkg::KIND_IDLE) |=> $stable(idle_r))
    else $error("idle total moved on a served tick");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    svc.valid |-> !in_ch.ready)
    else $error("input accepted while a tick is still in progress");

endmodule
